// ----- design/mselg_pkg.sv -----
package mselg_pkg;

   localparam int BATCH_W    = 16;
   localparam int SUM_W      = 48;
   localparam int GRAD_W     = 18;
   localparam int RSP_DATA_W = ((GRAD_W + SUM_W + 7) / 8) * 8;

   localparam int GRAD_POS_LIMIT = 131071;
   localparam int GRAD_NEG_LIMIT = 131072;

   localparam logic [SUM_W-1:0]  SUM_MAX  = '1;
   localparam logic [GRAD_W-1:0] GRAD_MAX = 18'h1FFFF;
   localparam logic [GRAD_W-1:0] GRAD_MIN = 18'h20000;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

// ----- design/mean_squared_error_loss_grad_unit.sv -----
// an accepted item is squared, added to the sum and divided for the gradient, then goes to the output register
// a last item also waits for the loss division of the sum before it goes to the output register
// a new item is taken only once the previous result is written out, which waits while the output register is full
// the radix-2 divider takes one quotient bit per cycle, first for the gradient
// and then, for a last item, for the loss; one item is in work at a time, a result waits in the output register
// synchronous active-high reset clears the sum, the sequencer and sets batch_size to 1
module mean_squared_error_loss_grad_unit
   import mselg_pkg::*;
#(
   parameter int SAMPLE_BITS = 16
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [BATCH_W-1:0]                    csr_wr_data,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // prediction, target
   input  logic [((2*SAMPLE_BITS+7)/8)*8-1:0]    req_tdata,
   input  logic                                  req_tlast,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // gradient, loss
   output logic [RSP_DATA_W-1:0]                 rsp_tdata,
   // loss_valid
   output logic                                  rsp_tuser
);

   localparam int DIFF_W   = SAMPLE_BITS + 1;
   localparam int SQ_W     = 2 * DIFF_W;
   localparam int GDIV_W   = DIFF_W + 1;
   localparam int DIV_W    = (SUM_W > GDIV_W) ? SUM_W : GDIV_W;
   localparam int STEP_W   = $clog2(DIV_W + 1);
   localparam int ACC_W    = ((SQ_W > SUM_W) ? SQ_W : SUM_W) + 1;

   typedef enum logic [2:0] {
      IDLE,
      SQUARE,
      ACCUM,
      GRAD_WAIT,
      LOSS_WAIT,
      DONE
   } state_type;

   state_type                state_ff, state_in;
   logic [BATCH_W-1:0]       batch_ff, batch_in;
   logic [SUM_W-1:0]         sum_ff, sum_in;
   logic signed [DIFF_W-1:0] diff_ff, diff_in;
   logic                     last_ff, last_in;
   logic [SQ_W-1:0]          sq_ff, sq_in;
   logic [GRAD_W-1:0]        grad_ff, grad_in;
   logic [SUM_W-1:0]         loss_ff, loss_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]    rsp_data_ff, rsp_data_in;
   logic                     rsp_user_ff, rsp_user_in;

   logic [DIFF_W-1:0]        mag;
   logic [ACC_W-1:0]         sum_ext;
   logic [GRAD_W-1:0]        grad_val;
   logic [BATCH_W-1:0]       denom;
   logic                     div_start;
   logic [STEP_W-1:0]        div_steps;
   logic [DIV_W-1:0]         div_dividend;
   logic [DIV_W-1:0]         div_quotient;
   div_status_type           div_status;
   logic                     req_xfer;

   assign req_xfer = req_tvalid && req_tready;
   assign denom    = (batch_ff == '0) ? BATCH_W'(1) : batch_ff;
   assign mag      = diff_ff[DIFF_W-1] ? DIFF_W'(-diff_ff) : DIFF_W'(diff_ff);
   assign sum_ext  = ACC_W'(sum_ff) + ACC_W'(sq_ff);

   always_comb begin
      if (diff_ff[DIFF_W-1]) begin
         if (div_quotient > DIV_W'(GRAD_NEG_LIMIT)) begin
            grad_val = GRAD_MIN;
         end else begin
            grad_val = GRAD_W'(DIV_W'(0) - div_quotient);
         end
      end else begin
         if (div_quotient > DIV_W'(GRAD_POS_LIMIT)) begin
            grad_val = GRAD_MAX;
         end else begin
            grad_val = GRAD_W'(div_quotient);
         end
      end
   end

   always_comb begin
      div_start    = 1'b0;
      div_steps    = STEP_W'(GDIV_W);
      div_dividend = DIV_W'({mag, 1'b0}) << (DIV_W - GDIV_W);
      if (state_ff == GRAD_WAIT) begin
         div_steps    = STEP_W'(SUM_W);
         div_dividend = DIV_W'(sum_ff) << (DIV_W - SUM_W);
      end
      if (state_ff == SQUARE) begin
         div_start = 1'b1;
      end else if (state_ff == GRAD_WAIT && div_status.done && last_ff) begin
         div_start = 1'b1;
      end
   end

   always_comb begin
      state_in     = state_ff;
      batch_in     = csr_wr_en ? csr_wr_data : batch_ff;
      sum_in       = sum_ff;
      diff_in      = diff_ff;
      last_in      = last_ff;
      sq_in        = sq_ff;
      grad_in      = grad_ff;
      loss_in      = loss_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      unique case (state_ff)
         IDLE: begin
            if (req_xfer) begin
               diff_in  = $signed({req_tdata[SAMPLE_BITS-1], req_tdata[SAMPLE_BITS-1:0]})
                        - $signed({req_tdata[2*SAMPLE_BITS-1],
                                   req_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]});
               last_in  = req_tlast;
               state_in = SQUARE;
            end
         end
         SQUARE: begin
            sq_in    = SQ_W'(mag * mag);
            state_in = ACCUM;
         end
         ACCUM: begin
            // saturating add of the square
            sum_in   = (sum_ext > ACC_W'(SUM_MAX)) ? SUM_MAX : sum_ext[SUM_W-1:0];
            state_in = GRAD_WAIT;
         end
         GRAD_WAIT: begin
            if (div_status.done) begin
               grad_in = grad_val;
               loss_in = '0;
               if (last_ff) begin
                  sum_in   = '0;
                  state_in = LOSS_WAIT;
               end else begin
                  state_in = DONE;
               end
            end
         end
         LOSS_WAIT: begin
            if (div_status.done) begin
               loss_in  = div_quotient[SUM_W-1:0];
               state_in = DONE;
            end
         end
         DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_DATA_W'({loss_ff, grad_ff});
               rsp_user_in  = last_ff;
               state_in     = IDLE;
            end
         end
         default: begin
            state_in = IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         batch_ff     <= BATCH_W'(1);
         sum_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         batch_ff     <= batch_in;
         sum_ff       <= sum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      diff_ff     <= diff_in;
      last_ff     <= last_in;
      sq_ff       <= sq_in;
      grad_ff     <= grad_in;
      loss_ff     <= loss_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   mselg_divider #(
      .DIV_W (DIV_W),
      .DEN_W (BATCH_W)
   ) u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .steps    (div_steps),
      .dividend (div_dividend),
      .denom    (denom),
      .status   (div_status),
      .quotient (div_quotient)
   );

   assign req_tready = (state_ff == IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      div_start |-> !div_status.busy)
      else $error("divider started while busy");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_xfer |=> !req_tready)
      else $error("input taken while an item is in work");

   a_loss_only_last: assert property (@(posedge clock) disable iff (reset)
      state_ff == LOSS_WAIT |-> last_ff)
      else $error("loss division on an item not marked last");

   a_zero_loss: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser |-> rsp_tdata[GRAD_W+SUM_W-1:GRAD_W] == '0)
      else $error("nonzero loss on an item not marked last");

   a_sum_cleared: assert property (@(posedge clock) disable iff (reset)
      state_ff == LOSS_WAIT |-> sum_ff == '0)
      else $error("sum not cleared after the last item");

endmodule

// ----- design/mselg_divider.sv -----
module mselg_divider
   import mselg_pkg::*;
#(
   parameter int DIV_W  = 48,
   parameter int DEN_W  = 16,
   parameter int STEP_W = $clog2(DIV_W + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [STEP_W-1:0] steps,
   input  logic [DIV_W-1:0]  dividend,
   input  logic [DEN_W-1:0]  denom,
   output div_status_type    status,
   output logic [DIV_W-1:0]  quotient
);

   logic [STEP_W-1:0] count_ff, count_in;
   logic [DIV_W-1:0]  quo_ff, quo_in;
   logic [DEN_W-1:0]  rem_ff, rem_in;
   logic [DEN_W-1:0]  den_ff, den_in;
   logic              done_ff, done_in;
   logic [DEN_W:0]    rem_shift;
   logic [DEN_W:0]    rem_diff;

   always_comb begin
      rem_shift = {rem_ff, quo_ff[DIV_W-1]};
      rem_diff  = rem_shift - {1'b0, den_ff};
      count_in  = count_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      den_in    = den_ff;
      done_in   = 1'b0;
      if (start) begin
         count_in = steps;
         quo_in   = dividend;
         rem_in   = '0;
         den_in   = denom;
      end else if (count_ff != '0) begin
         // one restoring step per cycle
         count_in = count_ff - STEP_W'(1);
         done_in  = (count_ff == STEP_W'(1));
         if (!rem_diff[DEN_W]) begin
            rem_in = rem_diff[DEN_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b1};
         end else begin
            rem_in = rem_shift[DEN_W-1:0];
            quo_in = {quo_ff[DIV_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         count_ff <= count_in;
         done_ff  <= done_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign status.busy = (count_ff != '0);
   assign status.done = done_ff;
   assign quotient    = quo_ff;

endmodule

// ----- verif/testbench.sv -----
`timescale 1ns / 1ps
module testbench;
   import mselg_pkg::*;

   localparam int SAMPLE_BITS   = 16;
   localparam int REQ_W         = ((2*SAMPLE_BITS+7)/8)*8;
   localparam int STALL_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = 150;
   localparam int STEADY_ITEMS  = 200;

   typedef struct packed {
      logic signed [SAMPLE_BITS-1:0] prediction;
      logic signed [SAMPLE_BITS-1:0] target;
      logic                          last;
   } sample_pair_type;

   typedef struct packed {
      logic [GRAD_W-1:0] gradient;
      logic [SUM_W-1:0]  loss;
      logic              loss_valid;
   } grad_loss_type;

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   csr_wr_en   = 1'b0;
   logic [BATCH_W-1:0]     csr_wr_data = '0;
   logic                   req_tvalid  = 1'b0;
   logic                   req_tready;
   logic [REQ_W-1:0]       req_tdata   = '0;
   logic                   req_tlast   = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready  = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tuser;

   mean_squared_error_loss_grad_unit #(.SAMPLE_BITS(SAMPLE_BITS)) dut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tuser   (rsp_tuser)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   sample_pair_type   pending_pairs[$];
   grad_loss_type     expected_grads[$];
   sample_pair_type   req_item = '0;
   logic           steady = 1'b0;
   logic [BATCH_W-1:0] batch_size_copy = 16'd1;
   logic [SUM_W-1:0]   square_sum_copy = '0;
   int errors = 0;
   int pairs_sent = 0;
   int results_checked = 0;
   int batch_settings = 0;
   int quiet_cycles = 0;

   function automatic grad_loss_type mse_grad_step(input sample_pair_type s);
      longint          diff;
      longint unsigned mag, sq, gmag, gneg, div, headroom;
      grad_loss_type   r;
      diff = longint'($signed(s.prediction)) - longint'($signed(s.target));
      mag = (diff < 0) ? -diff : diff;
      sq = mag * mag;
      div = (batch_size_copy == '0) ? 1 : batch_size_copy;
      gmag = (mag * 2) / div;
      gneg = -gmag;
      if (diff < 0)
         r.gradient = (gmag > GRAD_NEG_LIMIT) ? GRAD_MIN : gneg[GRAD_W-1:0];
      else
         r.gradient = (gmag > GRAD_POS_LIMIT) ? GRAD_MAX : gmag[GRAD_W-1:0];
      headroom = SUM_MAX - square_sum_copy;
      if (sq > headroom)
         square_sum_copy = SUM_MAX;
      else
         square_sum_copy = square_sum_copy + sq[SUM_W-1:0];
      r.loss = '0;
      r.loss_valid = s.last;
      if (s.last) begin
         r.loss = square_sum_copy / div;
         square_sum_copy = '0;
      end
      return r;
   endfunction

   // driver
   always @(posedge clock) begin : req_driver
      sample_pair_type nxt;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_grads.push_back(mse_grad_step(req_item));
            pairs_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_pairs.size() > 0 && (steady || $urandom_range(99) >= 22)) begin
               nxt = pending_pairs.pop_front();
               req_item   <= nxt;
               req_tdata  <= {nxt.target, nxt.prediction};
               req_tlast  <= nxt.last;
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin : rsp_monitor
      grad_loss_type want, got;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            got.gradient   = rsp_tdata[GRAD_W-1:0];
            got.loss       = rsp_tdata[GRAD_W +: SUM_W];
            got.loss_valid = rsp_tuser;
            results_checked++;
            if (expected_grads.size() == 0) begin
               $error("unexpected result transfer: gradient %0d loss %0d loss_valid %0b",
                      $signed(got.gradient), got.loss, got.loss_valid);
               errors++;
            end else begin
               want = expected_grads.pop_front();
               if (got.gradient !== want.gradient) begin
                  $error("gradient: expected %0d, actual %0d",
                         $signed(want.gradient), $signed(got.gradient));
                  errors++;
               end
               if (got.loss !== want.loss) begin
                  $error("loss: expected %0d, actual %0d", want.loss, got.loss);
                  errors++;
               end
               if (got.loss_valid !== want.loss_valid) begin
                  $error("loss_valid: expected %0b, actual %0b",
                         want.loss_valid, got.loss_valid);
                  errors++;
               end
            end
         end
         rsp_tready <= steady || ($urandom_range(99) >= 22);
      end
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("testbench NOT OK");
            $finish;
         end
      end
   end

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_pairs.size() != 0 || req_tvalid || expected_grads.size() != 0);
   endtask

   task automatic set_batch_size(input logic [BATCH_W-1:0] value);
      wait_drained();
      @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      batch_size_copy = value;
      batch_settings++;
      @(negedge clock);
   endtask

   task automatic add_pair(input int p, input int t, input bit l);
      sample_pair_type s;
      s.prediction = p[SAMPLE_BITS-1:0];
      s.target     = t[SAMPLE_BITS-1:0];
      s.last       = l;
      pending_pairs.push_back(s);
   endtask

   function automatic int pick_sample();
      int sel;
      sel = $urandom_range(99);
      if (sel < 4)  return -32768;
      if (sel < 8)  return 32767;
      if (sel < 10) return 0;
      if (sel < 12) return -1;
      if (sel < 25) return $signed(16'($urandom_range(255))) - 128;
      return $signed(16'($urandom));
   endfunction

   task automatic add_random_pairs(input int count);
      int frame_left;
      frame_left = $urandom_range(12, 1);
      repeat (count) begin
         frame_left--;
         add_pair(pick_sample(), pick_sample(), frame_left == 0);
         if (frame_left == 0)
            frame_left = ($urandom_range(9) == 0) ? $urandom_range(60, 13)
                                                  : $urandom_range(12, 1);
      end
   endtask

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // reset value of batch_size
      add_pair(32767, -32768, 0);
      add_pair(-32768, 32767, 0);
      add_pair(0, 0, 0);
      add_pair(1, 0, 0);
      add_pair(0, 1, 0);
      add_pair(32767, 32767, 1);
      add_pair(-32768, -32768, 1);
      add_pair(5, -3, 1);

      // zero batch size acts as one
      set_batch_size(16'd0);
      add_pair(100, -100, 0);
      add_pair(-1, 0, 1);

      set_batch_size(16'hFFFF);
      add_pair(32767, -32768, 0);
      add_pair(-32768, 32767, 0);
      add_pair(3, 0, 0);
      add_pair(-3, 0, 1);

      // truncation toward zero
      set_batch_size(16'd3);
      add_pair(7, 0, 0);
      add_pair(-7, 0, 0);
      add_pair(1, 0, 1);

      // long frame of extreme differences, no idling on either side
      set_batch_size(16'hFFFF);
      steady = 1'b1;
      for (int i = 0; i < STEADY_ITEMS; i++)
         if (i[0]) add_pair(32767, -32768, 0);
         else      add_pair(-32768, 32767, 0);
      add_pair(1, 0, 1);
      wait_drained();
      steady = 1'b0;

      set_batch_size(16'd1);
      add_random_pairs(230);
      set_batch_size(16'd2);
      add_random_pairs(230);
      set_batch_size(16'd0);
      add_random_pairs(220);
      set_batch_size(16'hFFFF);
      add_random_pairs(230);
      set_batch_size(16'd255);
      add_random_pairs(220);
      set_batch_size(16'($urandom_range(16, 1)));
      add_random_pairs(230);
      set_batch_size(16'($urandom_range(65535, 1)));
      add_random_pairs(230);

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("covered %0d input transfers and %0d result transfers over %0d batch sizes",
               pairs_sent, results_checked, batch_settings);
      $display("including extremes, zero batch size and a long frame without idling");
      if (errors == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

endmodule
